>>> design/kf_pkg.sv
// shared types, constants and the step microprogram of the kalman filter step
package kf_pkg;

    localparam int STATE_DIM = 2;
    localparam int CTRL_DIM  = 1;

    localparam int ACC_W  = 52;
    localparam int OPND_W = 33;
    localparam int PROD_W = 2 * OPND_W;
    localparam int DVD_W  = ACC_W + 17;
    localparam int CNT_W  = $clog2(DVD_W + 1);
    localparam int NUOP   = 80;
    localparam int PC_W   = $clog2(NUOP);
    localparam int NREG   = 30;
    localparam int RF_W   = $clog2(NREG);
    localparam int CODE_W = 6;
    localparam int NCODE  = 1 << CODE_W;
    localparam int IN_W   = 96;
    localparam int OUT_W  = 64;
    localparam int CFG_W  = 64;
    localparam int CIDX_W = 3;

    // configuration register indexes
    localparam logic [CIDX_W-1:0] CFG_TRANS = 3'd0;
    localparam logic [CIDX_W-1:0] CFG_CTRL  = 3'd1;
    localparam logic [CIDX_W-1:0] CFG_OBS   = 3'd2;
    localparam logic [CIDX_W-1:0] CFG_QN    = 3'd3;
    localparam logic [CIDX_W-1:0] CFG_RN    = 3'd4;
    localparam logic [CIDX_W-1:0] CFG_MINV  = 3'd5;
    localparam logic [CIDX_W-1:0] CFG_SKIP  = 3'd6;

    // operand codes
    localparam logic [CODE_W-1:0] C_ZERO = 6'd0;
    localparam logic [CODE_W-1:0] C_F0   = 6'd1;
    localparam logic [CODE_W-1:0] C_B0   = 6'd5;
    localparam logic [CODE_W-1:0] C_H0   = 6'd7;
    localparam logic [CODE_W-1:0] C_Q0   = 6'd11;
    localparam logic [CODE_W-1:0] C_R0   = 6'd15;
    localparam logic [CODE_W-1:0] C_U    = 6'd19;
    localparam logic [CODE_W-1:0] C_Z0   = 6'd20;
    localparam logic [CODE_W-1:0] C_Z1   = 6'd21;
    localparam logic [CODE_W-1:0] C_NS1  = 6'd22;
    localparam logic [CODE_W-1:0] C_NS2  = 6'd23;

    // register file bases
    localparam logic [RF_W-1:0] R_X   = 5'd0;
    localparam logic [RF_W-1:0] R_XP  = 5'd2;
    localparam logic [RF_W-1:0] R_P   = 5'd4;
    localparam logic [RF_W-1:0] R_PP  = 5'd8;
    localparam logic [RF_W-1:0] R_K   = 5'd12;
    localparam logic [RF_W-1:0] R_T   = 5'd16;
    localparam logic [RF_W-1:0] R_S   = 5'd20;
    localparam logic [RF_W-1:0] R_PHT = 5'd24;
    localparam logic [RF_W-1:0] R_R   = 5'd28;

    // equation ids
    localparam logic [2:0] EQ1 = 3'd0;
    localparam logic [2:0] EQ2 = 3'd1;
    localparam logic [2:0] EQ3 = 3'd2;
    localparam logic [2:0] EQ4 = 3'd3;
    localparam logic [2:0] EQ5 = 3'd4;

    // writeback kinds
    localparam logic [1:0] K_REG = 2'd0;
    localparam logic [1:0] K_DET = 2'd1;
    localparam logic [1:0] K_RES = 2'd2;
    localparam logic [1:0] K_DIV = 2'd3;

    // flags: {sh16, neg, first, last}
    localparam logic [3:0] FL_N  = 4'b0000;
    localparam logic [3:0] FL_L  = 4'b0001;
    localparam logic [3:0] FL_F  = 4'b0010;
    localparam logic [3:0] FL_NG = 4'b0100;
    localparam logic [3:0] FL_16 = 4'b1000;

    typedef struct packed {
        logic       mul_en;
        logic       acc_en;
        logic       first;
        logic       neg;
        logic       sh16;
    } mac_ctl_t;

    typedef struct packed {
        logic [2:0]        eq;
        logic [CODE_W-1:0] a;
        logic [CODE_W-1:0] b;
        logic [CODE_W-1:0] init;
        logic              sh16;
        logic              neg;
        logic              first;
        logic              last;
        logic [1:0]        kind;
        logic [RF_W-1:0]   dest;
    } uop_t;

    function automatic logic signed [31:0] sat32(input logic signed [ACC_W-1:0] v);
        logic signed [ACC_W-1:0] hi;
        logic signed [ACC_W-1:0] lo;
        hi = $signed({{(ACC_W-31){1'b0}}, {31{1'b1}}});
        lo = $signed({{(ACC_W-31){1'b1}}, {31{1'b0}}});
        if (v > hi) begin
            return 32'sh7fffffff;
        end else if (v < lo) begin
            return 32'sh80000000;
        end
        return v[31:0];
    endfunction

    function automatic logic [CODE_W-1:0] rc(input logic [RF_W-1:0] r);
        return {1'b1, r};
    endfunction

    function automatic logic [CODE_W-1:0] cf(input logic [1:0] k);
        return C_F0 + {4'b0, k};
    endfunction

    function automatic logic [CODE_W-1:0] ch(input logic [1:0] k);
        return C_H0 + {4'b0, k};
    endfunction

    function automatic uop_t mk(input logic [2:0] eq, input logic [CODE_W-1:0] a,
                                input logic [CODE_W-1:0] b, input logic [CODE_W-1:0] init,
                                input logic [3:0] fl, input logic [1:0] kind,
                                input logic [RF_W-1:0] dest);
        uop_t u;
        u.eq    = eq;
        u.a     = a;
        u.b     = b;
        u.init  = init;
        u.sh16  = fl[3];
        u.neg   = fl[2];
        u.first = fl[1];
        u.last  = fl[0];
        u.kind  = kind;
        u.dest  = dest;
        return u;
    endfunction

    // one multiply-accumulate term per entry
    function automatic uop_t uop_rom(input logic [PC_W-1:0] pc);
        uop_t u;
        unique case (pc)
            // prior = F*x + B*u
            7'd0:  u = mk(EQ1, cf(0), rc(R_X), C_ZERO, FL_F, K_REG, R_XP);
            7'd1:  u = mk(EQ1, cf(1), rc(R_X+5'd1), C_ZERO, FL_N, K_REG, R_XP);
            7'd2:  u = mk(EQ1, C_B0, C_U, C_ZERO, FL_L, K_REG, R_XP);
            7'd3:  u = mk(EQ1, cf(2), rc(R_X), C_ZERO, FL_F, K_REG, R_XP+5'd1);
            7'd4:  u = mk(EQ1, cf(3), rc(R_X+5'd1), C_ZERO, FL_N, K_REG, R_XP+5'd1);
            7'd5:  u = mk(EQ1, C_B0+6'd1, C_U, C_ZERO, FL_L, K_REG, R_XP+5'd1);
            // t = F*P
            7'd6:  u = mk(EQ2, cf(0), rc(R_P), C_ZERO, FL_F, K_REG, R_T);
            7'd7:  u = mk(EQ2, cf(1), rc(R_P+5'd2), C_ZERO, FL_L, K_REG, R_T);
            7'd8:  u = mk(EQ2, cf(0), rc(R_P+5'd1), C_ZERO, FL_F, K_REG, R_T+5'd1);
            7'd9:  u = mk(EQ2, cf(1), rc(R_P+5'd3), C_ZERO, FL_L, K_REG, R_T+5'd1);
            7'd10: u = mk(EQ2, cf(2), rc(R_P), C_ZERO, FL_F, K_REG, R_T+5'd2);
            7'd11: u = mk(EQ2, cf(3), rc(R_P+5'd2), C_ZERO, FL_L, K_REG, R_T+5'd2);
            7'd12: u = mk(EQ2, cf(2), rc(R_P+5'd1), C_ZERO, FL_F, K_REG, R_T+5'd3);
            7'd13: u = mk(EQ2, cf(3), rc(R_P+5'd3), C_ZERO, FL_L, K_REG, R_T+5'd3);
            // Pprior = Q + t*F^T
            7'd14: u = mk(EQ2, cf(0), rc(R_T), C_Q0, FL_F, K_REG, R_PP);
            7'd15: u = mk(EQ2, cf(1), rc(R_T+5'd1), C_Q0, FL_L, K_REG, R_PP);
            7'd16: u = mk(EQ2, cf(2), rc(R_T), C_Q0+6'd1, FL_F, K_REG, R_PP+5'd1);
            7'd17: u = mk(EQ2, cf(3), rc(R_T+5'd1), C_Q0+6'd1, FL_L, K_REG, R_PP+5'd1);
            7'd18: u = mk(EQ2, cf(0), rc(R_T+5'd2), C_Q0+6'd2, FL_F, K_REG, R_PP+5'd2);
            7'd19: u = mk(EQ2, cf(1), rc(R_T+5'd3), C_Q0+6'd2, FL_L, K_REG, R_PP+5'd2);
            7'd20: u = mk(EQ2, cf(2), rc(R_T+5'd2), C_Q0+6'd3, FL_F, K_REG, R_PP+5'd3);
            7'd21: u = mk(EQ2, cf(3), rc(R_T+5'd3), C_Q0+6'd3, FL_L, K_REG, R_PP+5'd3);
            // hp = H*Pprior
            7'd22: u = mk(EQ3, ch(0), rc(R_PP), C_ZERO, FL_F, K_REG, R_T);
            7'd23: u = mk(EQ3, ch(1), rc(R_PP+5'd2), C_ZERO, FL_L, K_REG, R_T);
            7'd24: u = mk(EQ3, ch(0), rc(R_PP+5'd1), C_ZERO, FL_F, K_REG, R_T+5'd1);
            7'd25: u = mk(EQ3, ch(1), rc(R_PP+5'd3), C_ZERO, FL_L, K_REG, R_T+5'd1);
            7'd26: u = mk(EQ3, ch(2), rc(R_PP), C_ZERO, FL_F, K_REG, R_T+5'd2);
            7'd27: u = mk(EQ3, ch(3), rc(R_PP+5'd2), C_ZERO, FL_L, K_REG, R_T+5'd2);
            7'd28: u = mk(EQ3, ch(2), rc(R_PP+5'd1), C_ZERO, FL_F, K_REG, R_T+5'd3);
            7'd29: u = mk(EQ3, ch(3), rc(R_PP+5'd3), C_ZERO, FL_L, K_REG, R_T+5'd3);
            // S = R + hp*H^T
            7'd30: u = mk(EQ3, ch(0), rc(R_T), C_R0, FL_F, K_REG, R_S);
            7'd31: u = mk(EQ3, ch(1), rc(R_T+5'd1), C_R0, FL_L, K_REG, R_S);
            7'd32: u = mk(EQ3, ch(2), rc(R_T), C_R0+6'd1, FL_F, K_REG, R_S+5'd1);
            7'd33: u = mk(EQ3, ch(3), rc(R_T+5'd1), C_R0+6'd1, FL_L, K_REG, R_S+5'd1);
            7'd34: u = mk(EQ3, ch(0), rc(R_T+5'd2), C_R0+6'd2, FL_F, K_REG, R_S+5'd2);
            7'd35: u = mk(EQ3, ch(1), rc(R_T+5'd3), C_R0+6'd2, FL_L, K_REG, R_S+5'd2);
            7'd36: u = mk(EQ3, ch(2), rc(R_T+5'd2), C_R0+6'd3, FL_F, K_REG, R_S+5'd3);
            7'd37: u = mk(EQ3, ch(3), rc(R_T+5'd3), C_R0+6'd3, FL_L, K_REG, R_S+5'd3);
            // pht = Pprior*H^T
            7'd38: u = mk(EQ3, ch(0), rc(R_PP), C_ZERO, FL_F, K_REG, R_PHT);
            7'd39: u = mk(EQ3, ch(1), rc(R_PP+5'd1), C_ZERO, FL_L, K_REG, R_PHT);
            7'd40: u = mk(EQ3, ch(2), rc(R_PP), C_ZERO, FL_F, K_REG, R_PHT+5'd1);
            7'd41: u = mk(EQ3, ch(3), rc(R_PP+5'd1), C_ZERO, FL_L, K_REG, R_PHT+5'd1);
            7'd42: u = mk(EQ3, ch(0), rc(R_PP+5'd2), C_ZERO, FL_F, K_REG, R_PHT+5'd2);
            7'd43: u = mk(EQ3, ch(1), rc(R_PP+5'd3), C_ZERO, FL_L, K_REG, R_PHT+5'd2);
            7'd44: u = mk(EQ3, ch(2), rc(R_PP+5'd2), C_ZERO, FL_F, K_REG, R_PHT+5'd3);
            7'd45: u = mk(EQ3, ch(3), rc(R_PP+5'd3), C_ZERO, FL_L, K_REG, R_PHT+5'd3);
            // determinant
            7'd46: u = mk(EQ3, rc(R_S), rc(R_S+5'd3), C_ZERO, FL_16|FL_F, K_DET, R_S);
            7'd47: u = mk(EQ3, rc(R_S+5'd1), rc(R_S+5'd2), C_ZERO, FL_16|FL_NG|FL_L,
                          K_DET, R_S);
            // gain numerators pht*adj(S), then divide
            7'd48: u = mk(EQ3, rc(R_PHT), rc(R_S+5'd3), C_ZERO, FL_16|FL_F, K_DIV, R_K);
            7'd49: u = mk(EQ3, rc(R_PHT+5'd1), C_NS2, C_ZERO, FL_16|FL_L, K_DIV, R_K);
            7'd50: u = mk(EQ3, rc(R_PHT), C_NS1, C_ZERO, FL_16|FL_F, K_DIV, R_K+5'd1);
            7'd51: u = mk(EQ3, rc(R_PHT+5'd1), rc(R_S), C_ZERO, FL_16|FL_L, K_DIV,
                          R_K+5'd1);
            7'd52: u = mk(EQ3, rc(R_PHT+5'd2), rc(R_S+5'd3), C_ZERO, FL_16|FL_F, K_DIV,
                          R_K+5'd2);
            7'd53: u = mk(EQ3, rc(R_PHT+5'd3), C_NS2, C_ZERO, FL_16|FL_L, K_DIV, R_K+5'd2);
            7'd54: u = mk(EQ3, rc(R_PHT+5'd2), C_NS1, C_ZERO, FL_16|FL_F, K_DIV, R_K+5'd3);
            7'd55: u = mk(EQ3, rc(R_PHT+5'd3), rc(R_S), C_ZERO, FL_16|FL_L, K_DIV,
                          R_K+5'd3);
            // residual r = z - H*prior
            7'd56: u = mk(EQ4, ch(0), rc(R_XP), C_Z0, FL_F, K_RES, R_R);
            7'd57: u = mk(EQ4, ch(1), rc(R_XP+5'd1), C_Z0, FL_L, K_RES, R_R);
            7'd58: u = mk(EQ4, ch(2), rc(R_XP), C_Z1, FL_F, K_RES, R_R+5'd1);
            7'd59: u = mk(EQ4, ch(3), rc(R_XP+5'd1), C_Z1, FL_L, K_RES, R_R+5'd1);
            // x = prior + K*r
            7'd60: u = mk(EQ4, rc(R_K), rc(R_R), rc(R_XP), FL_16|FL_F, K_REG, R_X);
            7'd61: u = mk(EQ4, rc(R_K+5'd1), rc(R_R+5'd1), rc(R_XP), FL_16|FL_L, K_REG, R_X);
            7'd62: u = mk(EQ4, rc(R_K+5'd2), rc(R_R), rc(R_XP+5'd1), FL_16|FL_F, K_REG,
                          R_X+5'd1);
            7'd63: u = mk(EQ4, rc(R_K+5'd3), rc(R_R+5'd1), rc(R_XP+5'd1), FL_16|FL_L,
                          K_REG, R_X+5'd1);
            // kh = K*H
            7'd64: u = mk(EQ5, ch(0), rc(R_K), C_ZERO, FL_F, K_REG, R_T);
            7'd65: u = mk(EQ5, ch(2), rc(R_K+5'd1), C_ZERO, FL_L, K_REG, R_T);
            7'd66: u = mk(EQ5, ch(1), rc(R_K), C_ZERO, FL_F, K_REG, R_T+5'd1);
            7'd67: u = mk(EQ5, ch(3), rc(R_K+5'd1), C_ZERO, FL_L, K_REG, R_T+5'd1);
            7'd68: u = mk(EQ5, ch(0), rc(R_K+5'd2), C_ZERO, FL_F, K_REG, R_T+5'd2);
            7'd69: u = mk(EQ5, ch(2), rc(R_K+5'd3), C_ZERO, FL_L, K_REG, R_T+5'd2);
            7'd70: u = mk(EQ5, ch(1), rc(R_K+5'd2), C_ZERO, FL_F, K_REG, R_T+5'd3);
            7'd71: u = mk(EQ5, ch(3), rc(R_K+5'd3), C_ZERO, FL_L, K_REG, R_T+5'd3);
            // P = Pprior - kh*Pprior
            7'd72: u = mk(EQ5, rc(R_T), rc(R_PP), rc(R_PP), FL_16|FL_NG|FL_F, K_REG, R_P);
            7'd73: u = mk(EQ5, rc(R_T+5'd1), rc(R_PP+5'd2), rc(R_PP), FL_16|FL_NG|FL_L,
                          K_REG, R_P);
            7'd74: u = mk(EQ5, rc(R_T), rc(R_PP+5'd1), rc(R_PP+5'd1), FL_16|FL_NG|FL_F,
                          K_REG, R_P+5'd1);
            7'd75: u = mk(EQ5, rc(R_T+5'd1), rc(R_PP+5'd3), rc(R_PP+5'd1),
                          FL_16|FL_NG|FL_L, K_REG, R_P+5'd1);
            7'd76: u = mk(EQ5, rc(R_T+5'd2), rc(R_PP), rc(R_PP+5'd2), FL_16|FL_NG|FL_F,
                          K_REG, R_P+5'd2);
            7'd77: u = mk(EQ5, rc(R_T+5'd3), rc(R_PP+5'd2), rc(R_PP+5'd2),
                          FL_16|FL_NG|FL_L, K_REG, R_P+5'd2);
            7'd78: u = mk(EQ5, rc(R_T+5'd2), rc(R_PP+5'd1), rc(R_PP+5'd3),
                          FL_16|FL_NG|FL_F, K_REG, R_P+5'd3);
            7'd79: u = mk(EQ5, rc(R_T+5'd3), rc(R_PP+5'd3), rc(R_PP+5'd3),
                          FL_16|FL_NG|FL_L, K_REG, R_P+5'd3);
            default: u = mk(EQ1, C_ZERO, C_ZERO, C_ZERO, FL_N, K_REG, R_X);
        endcase
        return u;
    endfunction

endpackage

>>> design/kf_mac.sv
// shared multiply, round and accumulate unit
module kf_mac (
    input  logic                                aclk,
    input  kf_pkg::mac_ctl_t                    ctl,
    input  logic signed [kf_pkg::OPND_W-1:0]    a,
    input  logic signed [kf_pkg::OPND_W-1:0]    b,
    input  logic signed [kf_pkg::ACC_W-1:0]     init,
    output logic signed [kf_pkg::ACC_W-1:0]     acc
);

    logic signed [kf_pkg::PROD_W-1:0] prod_reg;
    logic signed [kf_pkg::ACC_W-1:0]  acc_reg;
    logic signed [kf_pkg::ACC_W-1:0]  acc_next;
    logic signed [kf_pkg::PROD_W-1:0] rnd12;
    logic signed [kf_pkg::PROD_W-1:0] rnd16;
    logic signed [kf_pkg::ACC_W-1:0]  term;
    logic signed [kf_pkg::ACC_W-1:0]  base;

    always_ff @(posedge aclk) begin
        if (ctl.mul_en) begin
            prod_reg <= a * b;
        end
        if (ctl.acc_en) begin
            acc_reg <= acc_next;
        end
    end

    // round half up then floor
    always_comb begin
        rnd12    = (prod_reg + $signed(kf_pkg::PROD_W'(2048))) >>> 12;
        rnd16    = (prod_reg + $signed(kf_pkg::PROD_W'(32768))) >>> 16;
        term     = ctl.sh16 ? rnd16[kf_pkg::ACC_W-1:0] : rnd12[kf_pkg::ACC_W-1:0];
        base     = ctl.first ? init : acc_reg;
        acc_next = ctl.neg ? (base - term) : (base + term);
    end

    assign acc = acc_reg;

endmodule

>>> design/kf_div.sv
// restoring divider for the gain, one quotient bit per cycle
module kf_div (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              start,
    input  logic signed [kf_pkg::ACC_W-1:0]   num,
    input  logic signed [kf_pkg::ACC_W-1:0]   den,
    output logic                              done,
    output logic signed [31:0]                quot
);

    logic [kf_pkg::DVD_W-1:0] dvd_reg, dvd_next;
    logic [kf_pkg::ACC_W:0]   rem_reg, rem_next;
    logic [kf_pkg::DVD_W-1:0] quo_reg, quo_next;
    logic [kf_pkg::ACC_W-1:0] den_reg;
    logic                     neg_reg;
    logic [kf_pkg::CNT_W-1:0] cnt_reg, cnt_next;
    logic                     busy_reg, busy_next;
    logic                     done_reg, done_next;
    logic signed [31:0]       quot_reg, quot_next;
    logic [kf_pkg::ACC_W-1:0] un, ud;
    logic [kf_pkg::DVD_W-1:0] dvd_init;
    logic [kf_pkg::ACC_W:0]   rem_sh;
    logic                     ge;

    always_comb begin
        un       = num[kf_pkg::ACC_W-1] ? kf_pkg::ACC_W'(-num) : kf_pkg::ACC_W'(num);
        ud       = den[kf_pkg::ACC_W-1] ? kf_pkg::ACC_W'(-den) : kf_pkg::ACC_W'(den);
        dvd_init = {1'b0, un, 16'b0} + kf_pkg::DVD_W'(ud >> 1);
        rem_sh   = {rem_reg[kf_pkg::ACC_W-1:0], dvd_reg[kf_pkg::DVD_W-1]};
        ge       = rem_sh >= {1'b0, den_reg};
        rem_next = ge ? (rem_sh - {1'b0, den_reg}) : rem_sh;
        quo_next = {quo_reg[kf_pkg::DVD_W-2:0], ge};
        dvd_next = {dvd_reg[kf_pkg::DVD_W-2:0], 1'b0};
        cnt_next = cnt_reg + 1'b1;
        busy_next = busy_reg;
        done_next = 1'b0;
        quot_next = quot_reg;
        if (start) begin
            busy_next = 1'b1;
            cnt_next  = '0;
        end else if (busy_reg && (cnt_reg == kf_pkg::CNT_W'(kf_pkg::DVD_W - 1))) begin
            busy_next = 1'b0;
            done_next = 1'b1;
            // saturate the signed quotient
            if (neg_reg) begin
                quot_next = (|quo_next[kf_pkg::DVD_W-1:31]) ? 32'sh80000000
                                                            : -$signed(quo_next[31:0]);
            end else begin
                quot_next = (|quo_next[kf_pkg::DVD_W-1:31]) ? 32'sh7fffffff
                                                            : $signed(quo_next[31:0]);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
        quot_reg <= quot_next;
        if (start) begin
            dvd_reg <= dvd_init;
            rem_reg <= '0;
            quo_reg <= '0;
            den_reg <= ud;
            neg_reg <= num[kf_pkg::ACC_W-1] ^ den[kf_pkg::ACC_W-1];
            cnt_reg <= cnt_next;
        end else if (busy_reg) begin
            dvd_reg <= dvd_next;
            rem_reg <= rem_next;
            quo_reg <= quo_next;
            cnt_reg <= cnt_next;
        end
    end

    assign done = done_reg;
    assign quot = quot_reg;

endmodule

>>> design/linear_kalman_filter_step.sv
// top level of the two-state kalman filter step with its sequencer and register file
//
// One input item (two measurements and a control value) runs one predict and
// correct step and gives one item with the new state estimate. A small sequencer
// steps through an 80-entry microprogram; each entry is one product that the
// shared multiply-accumulate unit forms in a multiply state and then a round and
// accumulate state, and every finished matrix entry then passes a writeback state.
// The four gain entries each go through a bit-serial divider, or are written as
// zero when the determinant is zero. Skipped equations pass the multiply state
// once per product, with no writeback and no divides. The block takes a new
// item only when idle; a finished result waits in the output register until it
// is taken.
module linear_kalman_filter_step (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [kf_pkg::IN_W-1:0]        s_tdata,   // meas_a, meas_b, ctrl_in
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [kf_pkg::OUT_W-1:0]       m_tdata,   // est_a, est_b
    input  logic                           cfg_wr_en,
    input  logic [kf_pkg::CIDX_W-1:0]      cfg_index,
    input  logic [kf_pkg::CFG_W-1:0]       cfg_wdata
);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_MUL   = 3'd1;
    localparam logic [2:0] ST_ACC   = 3'd2;
    localparam logic [2:0] ST_WB    = 3'd3;
    localparam logic [2:0] ST_DIV   = 3'd4;
    localparam logic [2:0] ST_CLAMP = 3'd5;
    localparam logic [2:0] ST_OUT   = 3'd6;

    // configuration registers
    logic [63:0] trans_reg, obs_reg, qn_reg, rn_reg, minv_reg;
    logic [31:0] ctrl_reg;
    logic [4:0]  skip_reg;

    // filter state and scratch words
    logic signed [31:0] rf_reg [kf_pkg::NREG];
    logic signed [31:0] z0_reg, z1_reg, u_reg;
    logic signed [kf_pkg::ACC_W-1:0] det_reg;

    logic [2:0]              state_reg, state_next;
    logic [kf_pkg::PC_W-1:0] pc_reg, pc_next;
    logic                    out_valid_reg, out_valid_next;
    logic [kf_pkg::OUT_W-1:0] out_data_reg;

    kf_pkg::uop_t     uop;
    kf_pkg::mac_ctl_t mac_ctl;
    logic             skip_now;
    logic             pc_end;

    logic signed [kf_pkg::OPND_W-1:0] opnd [kf_pkg::NCODE];
    logic signed [kf_pkg::OPND_W-1:0] a_val, b_val, i_val;
    logic signed [kf_pkg::ACC_W-1:0]  init_val;
    logic signed [kf_pkg::ACC_W-1:0]  acc;
    logic signed [kf_pkg::ACC_W-1:0]  res_diff;
    logic signed [31:0]               acc_sat;

    // register file write port
    logic                     wr_en;
    logic [kf_pkg::RF_W-1:0]  wr_idx;
    logic signed [31:0]       wr_data;
    logic                     det_we;
    logic                     div_start;
    logic                     div_done;
    logic signed [31:0]       div_q;
    logic                     out_load;
    logic                     in_acc;

    assign uop      = kf_pkg::uop_rom(pc_reg);
    assign skip_now = skip_reg[uop.eq];
    assign pc_end   = (pc_reg == kf_pkg::PC_W'(kf_pkg::NUOP - 1));
    assign in_acc   = s_tvalid && s_tready;

    // operand table: config entries, inputs and register file words
    always_comb begin
        for (int c = 0; c < kf_pkg::NCODE; c++) begin
            opnd[c] = '0;
        end
        for (int k = 0; k < 4; k++) begin
            opnd[int'(kf_pkg::C_F0) + k] = kf_pkg::OPND_W'($signed(trans_reg[16*k +: 16]));
            opnd[int'(kf_pkg::C_H0) + k] = kf_pkg::OPND_W'($signed(obs_reg[16*k +: 16]));
            // noise entries come in as Q4.12 and are shifted left by four into Q16.16
            opnd[int'(kf_pkg::C_Q0) + k] = $signed({{13{qn_reg[16*k+15]}},
                                                    qn_reg[16*k +: 16], 4'b0});
            opnd[int'(kf_pkg::C_R0) + k] = $signed({{13{rn_reg[16*k+15]}},
                                                    rn_reg[16*k +: 16], 4'b0});
        end
        for (int k = 0; k < 2; k++) begin
            opnd[int'(kf_pkg::C_B0) + k] = kf_pkg::OPND_W'($signed(ctrl_reg[16*k +: 16]));
        end
        opnd[kf_pkg::C_U]   = kf_pkg::OPND_W'(u_reg);
        opnd[kf_pkg::C_Z0]  = kf_pkg::OPND_W'(z0_reg);
        opnd[kf_pkg::C_Z1]  = kf_pkg::OPND_W'(z1_reg);
        // negated off-diagonal of S for the adjugate
        opnd[kf_pkg::C_NS1] = -kf_pkg::OPND_W'(rf_reg[kf_pkg::R_S + 5'd1]);
        opnd[kf_pkg::C_NS2] = -kf_pkg::OPND_W'(rf_reg[kf_pkg::R_S + 5'd2]);
        for (int r = 0; r < kf_pkg::NREG; r++) begin
            opnd[32 + r] = kf_pkg::OPND_W'(rf_reg[r]);
        end
    end

    always_comb begin
        a_val    = opnd[uop.a];
        b_val    = opnd[uop.b];
        i_val    = opnd[uop.init];
        // residual entries start from zero; z is taken at writeback
        init_val = (uop.kind == kf_pkg::K_RES) ? '0 : kf_pkg::ACC_W'(i_val);
    end

    always_comb begin
        mac_ctl.mul_en = (state_reg == ST_MUL) && !skip_now;
        mac_ctl.acc_en = (state_reg == ST_ACC);
        mac_ctl.first  = uop.first;
        mac_ctl.neg    = uop.neg;
        mac_ctl.sh16   = uop.sh16;
    end

    kf_mac u_mac (
        .aclk (aclk),
        .ctl  (mac_ctl),
        .a    (a_val),
        .b    (b_val),
        .init (init_val),
        .acc  (acc)
    );

    kf_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start),
        .num     (acc),
        .den     (det_reg),
        .done    (div_done),
        .quot    (div_q)
    );

    always_comb begin
        acc_sat  = kf_pkg::sat32(acc);
        res_diff = kf_pkg::ACC_W'(i_val) - kf_pkg::ACC_W'(acc_sat);
    end

    // sequencer
    always_comb begin
        state_next = state_reg;
        pc_next    = pc_reg;
        wr_en      = 1'b0;
        wr_idx     = uop.dest;
        wr_data    = acc_sat;
        det_we     = 1'b0;
        div_start  = 1'b0;
        out_load   = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    pc_next    = '0;
                    state_next = ST_MUL;
                end
            end
            ST_MUL: begin
                if (skip_now) begin
                    // skipped equation keeps its stored result
                    if (pc_end) begin
                        state_next = ST_CLAMP;
                    end else begin
                        pc_next = pc_reg + 1'b1;
                    end
                end else begin
                    state_next = ST_ACC;
                end
            end
            ST_ACC: begin
                if (uop.last) begin
                    state_next = ST_WB;
                end else begin
                    pc_next    = pc_reg + 1'b1;
                    state_next = ST_MUL;
                end
            end
            ST_WB: begin
                state_next = pc_end ? ST_CLAMP : ST_MUL;
                pc_next    = pc_end ? pc_reg : pc_reg + 1'b1;
                unique case (uop.kind)
                    kf_pkg::K_REG: begin
                        wr_en = 1'b1;
                    end
                    kf_pkg::K_RES: begin
                        wr_en   = 1'b1;
                        wr_data = kf_pkg::sat32(res_diff);
                    end
                    kf_pkg::K_DET: begin
                        det_we = 1'b1;
                    end
                    kf_pkg::K_DIV: begin
                        if (det_reg == '0) begin
                            // singular innovation matrix: gain held at zero
                            wr_en   = 1'b1;
                            wr_data = '0;
                        end else begin
                            div_start  = 1'b1;
                            state_next = ST_DIV;
                            pc_next    = pc_reg;
                        end
                    end
                    default: begin
                    end
                endcase
            end
            ST_DIV: begin
                if (div_done) begin
                    wr_en   = 1'b1;
                    wr_data = div_q;
                    if (pc_end) begin
                        state_next = ST_CLAMP;
                    end else begin
                        pc_next    = pc_reg + 1'b1;
                        state_next = ST_MUL;
                    end
                end
            end
            ST_CLAMP: begin
                state_next = ST_OUT;
            end
            ST_OUT: begin
                if (!out_valid_reg || m_tready) begin
                    out_load   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        out_valid_next = out_valid_reg;
        if (out_load) begin
            out_valid_next = 1'b1;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            pc_reg        <= '0;
            out_valid_reg <= 1'b0;
            trans_reg     <= '0;
            ctrl_reg      <= '0;
            obs_reg       <= '0;
            qn_reg        <= '0;
            rn_reg        <= '0;
            minv_reg      <= '0;
            skip_reg      <= '0;
            for (int r = 0; r < kf_pkg::NREG; r++) begin
                rf_reg[r] <= '0;
            end
        end else begin
            state_reg     <= state_next;
            pc_reg        <= pc_next;
            out_valid_reg <= out_valid_next;
            if (cfg_wr_en) begin
                unique case (cfg_index)
                    kf_pkg::CFG_TRANS: trans_reg <= cfg_wdata;
                    kf_pkg::CFG_CTRL:  ctrl_reg  <= cfg_wdata[31:0];
                    kf_pkg::CFG_OBS:   obs_reg   <= cfg_wdata;
                    kf_pkg::CFG_QN:    qn_reg    <= cfg_wdata;
                    kf_pkg::CFG_RN:    rn_reg    <= cfg_wdata;
                    kf_pkg::CFG_MINV:  minv_reg  <= cfg_wdata;
                    kf_pkg::CFG_SKIP:  skip_reg  <= cfg_wdata[4:0];
                    default: begin
                    end
                endcase
            end
            if (wr_en) begin
                rf_reg[wr_idx] <= wr_data;
            end
            // diagonal floor, applied every step
            if (state_reg == ST_CLAMP) begin
                if (rf_reg[kf_pkg::R_P] < $signed(minv_reg[31:0])) begin
                    rf_reg[kf_pkg::R_P] <= $signed(minv_reg[31:0]);
                end
                if (rf_reg[kf_pkg::R_P + 5'd3] < $signed(minv_reg[63:32])) begin
                    rf_reg[kf_pkg::R_P + 5'd3] <= $signed(minv_reg[63:32]);
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (in_acc) begin
            z0_reg <= $signed(s_tdata[31:0]);
            z1_reg <= $signed(s_tdata[63:32]);
            u_reg  <= $signed(s_tdata[95:64]);
        end
        if (det_we) begin
            det_reg <= acc;
        end
        if (out_load) begin
            out_data_reg <= {rf_reg[kf_pkg::R_X + 5'd1], rf_reg[kf_pkg::R_X]};
        end
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    // divider only runs on a nonzero determinant
    a_div_det: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_DIV |-> det_reg != '0)
        else $error("divider busy with zero determinant");

    // an accepted item starts the microprogram from its first entry
    a_start: assert property (@(posedge aclk) disable iff (!aresetn)
        in_acc |=> (state_reg == ST_MUL) && (pc_reg == '0))
        else $error("step did not start at program entry zero");

    // program counter stays inside the microprogram
    a_pc_range: assert property (@(posedge aclk) disable iff (!aresetn)
        pc_reg <= kf_pkg::PC_W'(kf_pkg::NUOP - 1))
        else $error("program counter out of range");

    // the output register is loaded only when it is free or being drained
    a_out_free: assert property (@(posedge aclk) disable iff (!aresetn)
        out_load |-> (!out_valid_reg || m_tready))
        else $error("result overwritten before it was taken");

endmodule

>>> verif/linear_kalman_filter_step_tb.sv
// self-checking testbench for the two-state kalman filter step
module linear_kalman_filter_step_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import kf_pkg::*;

    // skip mask bits, one per equation
    localparam logic [4:0] SKIP_PRIOR = 5'b00001;
    localparam logic [4:0] SKIP_PPRI  = 5'b00010;
    localparam logic [4:0] SKIP_GAIN  = 5'b00100;
    localparam logic [4:0] SKIP_STATE = 5'b01000;
    localparam logic [4:0] SKIP_COV   = 5'b10000;

    // bit-exact model of one filter step plus the queue of expected estimates
    class kf_scoreboard;
        logic [63:0]        regs [7];
        logic signed [31:0] x [2];
        logic signed [31:0] xp [2];
        logic signed [31:0] p [4];
        logic signed [31:0] pp [4];
        logic signed [31:0] k [4];
        logic [OUT_W-1:0]   est_q [$];
        int                 errors;
        int                 checked;

        function new();
            foreach (regs[i]) regs[i] = '0;
            foreach (x[i]) begin x[i] = 0; xp[i] = 0; end
            foreach (p[i]) begin p[i] = 0; pp[i] = 0; k[i] = 0; end
            errors = 0;
            checked = 0;
        endfunction

        function void write_reg(int idx, logic [63:0] v);
            regs[idx] = v;
        endfunction

        function longint sat(longint v);
            if (v > 64'sh7fffffff) return 64'sh7fffffff;
            if (v < -64'sh80000000) return -64'sh80000000;
            return v;
        endfunction

        // round half up then floor
        function longint rsh(longint v, int s);
            return (v + (64'sd1 <<< (s - 1))) >>> s;
        endfunction

        function longint e16(logic [63:0] r, int idx);
            logic [15:0] w;
            w = r[16*idx +: 16];
            return longint'($signed(w));
        endfunction

        function longint mq12(longint m, longint v);
            return rsh(m * v, 12);
        endfunction

        function longint mq16(longint a, longint b);
            return rsh(a * b, 16);
        endfunction

        function longint fm(int i, int j); return e16(regs[CFG_TRANS], i*2 + j); endfunction
        function longint hm(int i, int j); return e16(regs[CFG_OBS], i*2 + j); endfunction

        // rounded division, ties away from zero, saturated
        function longint div_round(longint num, longint den);
            longint unsigned un, ud, q;
            un = num < 0 ? -num : num;
            ud = den < 0 ? -den : den;
            q = ((un << 16) + ud / 2) / ud;
            if ((num < 0) != (den < 0)) begin
                if (q >= 64'h80000000) return -64'sh80000000;
                return -longint'(q);
            end
            if (q > 64'h7fffffff) return 64'sh7fffffff;
            return longint'(q);
        endfunction

        // run one step on an accepted item and queue the new estimate
        function void note_input(logic [IN_W-1:0] d);
            longint z [2];
            longint u, acc, det, lo;
            longint t [4];
            longint hp [4];
            longint s [4];
            longint pht [4];
            longint adj [4];
            longint res [2];
            logic [4:0] skip;
            z[0] = longint'($signed(d[31:0]));
            z[1] = longint'($signed(d[63:32]));
            u = longint'($signed(d[95:64]));
            skip = regs[CFG_SKIP][4:0];

            if (!(skip & SKIP_PRIOR)) begin
                for (int i = 0; i < 2; i++) begin
                    acc = mq12(fm(i, 0), x[0]) + mq12(fm(i, 1), x[1])
                        + mq12(e16(regs[CFG_CTRL], i), u);
                    xp[i] = sat(acc);
                end
            end
            if (!(skip & SKIP_PPRI)) begin
                for (int i = 0; i < 2; i++)
                    for (int j = 0; j < 2; j++)
                        t[i*2+j] = sat(mq12(fm(i, 0), p[j]) + mq12(fm(i, 1), p[2+j]));
                for (int i = 0; i < 2; i++)
                    for (int j = 0; j < 2; j++) begin
                        acc = e16(regs[CFG_QN], i*2+j) * 16;
                        for (int c = 0; c < 2; c++) acc += mq12(fm(j, c), t[i*2+c]);
                        pp[i*2+j] = sat(acc);
                    end
            end
            if (!(skip & SKIP_GAIN)) begin
                for (int m = 0; m < 2; m++)
                    for (int j = 0; j < 2; j++)
                        hp[m*2+j] = sat(mq12(hm(m, 0), pp[j]) + mq12(hm(m, 1), pp[2+j]));
                for (int m = 0; m < 2; m++)
                    for (int n = 0; n < 2; n++) begin
                        acc = e16(regs[CFG_RN], m*2+n) * 16;
                        for (int c = 0; c < 2; c++) acc += mq12(hm(n, c), hp[m*2+c]);
                        s[m*2+n] = sat(acc);
                    end
                for (int i = 0; i < 2; i++)
                    for (int m = 0; m < 2; m++)
                        pht[i*2+m] = sat(mq12(hm(m, 0), pp[i*2]) + mq12(hm(m, 1), pp[i*2+1]));
                det = mq16(s[0], s[3]) - mq16(s[1], s[2]);
                adj[0] = s[3]; adj[1] = -s[1]; adj[2] = -s[2]; adj[3] = s[0];
                for (int i = 0; i < 2; i++)
                    for (int n = 0; n < 2; n++) begin
                        if (det == 0) begin
                            k[i*2+n] = 0;
                        end else begin
                            acc = mq16(pht[i*2], adj[n]) + mq16(pht[i*2+1], adj[2+n]);
                            k[i*2+n] = div_round(acc, det);
                        end
                    end
            end
            if (!(skip & SKIP_STATE)) begin
                for (int m = 0; m < 2; m++) begin
                    acc = mq12(hm(m, 0), xp[0]) + mq12(hm(m, 1), xp[1]);
                    res[m] = sat(z[m] - sat(acc));
                end
                for (int i = 0; i < 2; i++)
                    x[i] = sat(xp[i] + mq16(k[i*2], res[0]) + mq16(k[i*2+1], res[1]));
            end
            if (!(skip & SKIP_COV)) begin
                for (int i = 0; i < 2; i++)
                    for (int j = 0; j < 2; j++)
                        t[i*2+j] = sat(mq12(hm(0, j), k[i*2]) + mq12(hm(1, j), k[i*2+1]));
                for (int i = 0; i < 2; i++)
                    for (int j = 0; j < 2; j++) begin
                        acc = pp[i*2+j];
                        for (int c = 0; c < 2; c++) acc -= mq16(t[i*2+c], pp[c*2+j]);
                        p[i*2+j] = sat(acc);
                    end
            end
            for (int i = 0; i < 2; i++) begin
                lo = longint'($signed(regs[CFG_MINV][32*i +: 32]));
                if (longint'(p[i*3]) < lo) p[i*3] = lo;
            end
            est_q.push_back({x[1], x[0]});
        endfunction

        function void check_result(logic [OUT_W-1:0] got);
            logic [OUT_W-1:0] want;
            if (est_q.size() == 0) begin
                $error("unexpected result item %h", got);
                errors++;
                return;
            end
            want = est_q.pop_front();
            checked++;
            if (got[31:0] !== want[31:0]) begin
                $error("est_a expected %h actual %h", want[31:0], got[31:0]);
                errors++;
            end
            if (got[63:32] !== want[63:32]) begin
                $error("est_b expected %h actual %h", want[63:32], got[63:32]);
                errors++;
            end
        endfunction

        function int pending();
            return est_q.size();
        endfunction
    endclass

    logic               aclk = 1'b0;
    logic               aresetn = 1'b0;
    logic               s_tvalid = 1'b0;
    logic               s_tready;
    logic [IN_W-1:0]    s_tdata = '0;     // meas_a, meas_b, ctrl_in
    logic               m_tvalid;
    logic               m_tready = 1'b0;
    logic [OUT_W-1:0]   m_tdata;          // est_a, est_b
    logic               cfg_wr_en = 1'b0;
    logic [CIDX_W-1:0]  cfg_index = '0;
    logic [CFG_W-1:0]   cfg_wdata = '0;

    kf_scoreboard sb = new();
    bit           hold_req = 1'b0;   // asks the receiver for one long stall
    int           sent = 0;
    int           cfg_sets = 0;

    always #5 aclk = ~aclk;

    linear_kalman_filter_step u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    // receiver: check every taken item, stall on its own pattern
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            sb.check_result(m_tdata);
        end
    end

    initial begin : receiver
        int mode;
        @(posedge aresetn);
        forever begin
            if (hold_req) begin
                // long hold-off, block fills and must stall its input
                m_tready <= 1'b0;
                repeat (3000) @(posedge aclk);
                hold_req = 1'b0;
            end
            mode = $urandom_range(0, 9);
            if (mode < 5) begin
                m_tready <= 1'b1;
                repeat ($urandom_range(1, 40)) @(posedge aclk);
            end else if (mode < 8) begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 30)) @(posedge aclk);
            end else begin
                // toggle every cycle for a while
                repeat ($urandom_range(2, 12)) begin
                    m_tready <= ~m_tready;
                    @(posedge aclk);
                end
            end
        end
    end

    // hold one item on the input until the block takes it; valid stays high after
    task automatic send_item(logic [IN_W-1:0] d);
        s_tdata  <= d;
        s_tvalid <= 1'b1;
        do @(posedge aclk); while (!s_tready);
        sb.note_input(d);
        sent++;
    endtask

    task automatic sender_gap(int n);
        s_tvalid <= 1'b0;
        repeat (n) @(posedge aclk);
    endtask

    // random bursts with random gaps between them
    task automatic send_paced(logic [IN_W-1:0] d);
        send_item(d);
        if ($urandom_range(0, 5) == 0) sender_gap($urandom_range(1, 20));
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        while (sb.pending() != 0) @(posedge aclk);
        // the block may still be retiring its last step
        repeat (20) @(posedge aclk);
    endtask

    // write all seven registers while the block is idle
    task automatic load_config(logic [63:0] v [7]);
        for (int i = 0; i < 7; i++) begin
            cfg_wr_en <= 1'b1;
            cfg_index <= CIDX_W'(i);
            cfg_wdata <= v[i];
            @(posedge aclk);
            sb.write_reg(i, v[i]);
        end
        cfg_wr_en <= 1'b0;
        @(posedge aclk);
        cfg_sets++;
    endtask

    function automatic logic [63:0] pack4(logic [15:0] a, logic [15:0] b,
                                          logic [15:0] c, logic [15:0] d);
        return {d, c, b, a};
    endfunction

    function automatic logic [15:0] near(int base, int spread);
        return 16'(base + $urandom_range(0, 2*spread) - spread);
    endfunction

    // tracking-like matrices with random perturbation
    function automatic void sane_config(ref logic [63:0] v [7]);
        v[CFG_TRANS] = pack4(near(16'h1000, 64), near(0, 512), near(0, 64), near(16'h1000, 64));
        v[CFG_CTRL]  = {32'b0, near(0, 256), near(16'h1000, 512)};
        v[CFG_OBS]   = pack4(near(16'h1000, 256), near(0, 256), near(0, 256),
                             near(16'h1000, 256));
        v[CFG_QN]    = pack4(16'($urandom_range(0, 256)), near(0, 8), near(0, 8),
                             16'($urandom_range(0, 256)));
        v[CFG_RN]    = pack4(16'($urandom_range(1, 16'h4000)), near(0, 16), near(0, 16),
                             16'($urandom_range(1, 16'h4000)));
        v[CFG_MINV]  = {32'($urandom_range(0, 32'h100)), 32'($urandom_range(0, 32'h100))};
        v[CFG_SKIP]  = ($urandom_range(0, 3) == 0) ? 64'($urandom_range(0, 31)) : 64'd0;
    endfunction

    function automatic void wild_config(ref logic [63:0] v [7]);
        for (int i = 0; i < 7; i++) v[i] = {$urandom, $urandom};
        v[CFG_CTRL] &= 64'hffff_ffff;
        v[CFG_SKIP] &= 64'h1f;
    endfunction

    function automatic logic [IN_W-1:0] rand_item(bit wild);
        logic [31:0] a, b, c;
        if (wild) begin
            a = $urandom; b = $urandom; c = $urandom;
        end else begin
            a = 32'($urandom_range(0, 32'h000a_0000)) - 32'h0005_0000;
            b = 32'($urandom_range(0, 32'h000a_0000)) - 32'h0005_0000;
            c = 32'($urandom_range(0, 32'h0002_0000)) - 32'h0001_0000;
        end
        return {c, b, a};
    endfunction

    initial begin : stimulus
        logic [63:0] cv [7];
        logic [31:0] edges [6];
        int          n_items;
        edges = '{32'h7fff_ffff, 32'h8000_0000, 32'h0, 32'hffff_ffff,
                  32'h0001_0000, 32'hffff_0000};

        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // registers at reset: everything is zero, estimate stays zero
        send_item({edges[0], edges[1], edges[0]});
        send_item({edges[1], edges[0], edges[1]});
        drain();

        // tracking setup, measurement extremes
        cv[CFG_TRANS] = pack4(16'h1000, 16'h0100, 16'h0000, 16'h1000);
        cv[CFG_CTRL]  = {32'b0, 16'h1000, 16'h0080};
        cv[CFG_OBS]   = pack4(16'h1000, 16'h0000, 16'h0000, 16'h1000);
        cv[CFG_QN]    = pack4(16'h0010, 16'h0000, 16'h0000, 16'h0010);
        cv[CFG_RN]    = pack4(16'h1000, 16'h0000, 16'h0000, 16'h1000);
        cv[CFG_MINV]  = {32'h0000_0100, 32'h0000_0040};
        cv[CFG_SKIP]  = '0;
        load_config(cv);
        for (int i = 0; i < 6; i++) send_item({edges[5-i], edges[i], edges[(i+2)%6]});
        drain();

        // each equation skipped on its own
        for (int b = 0; b < 5; b++) begin
            cv[CFG_SKIP] = 64'(1 << b);
            load_config(cv);
            send_item(rand_item(1'b0));
            send_item(rand_item(1'b0));
            drain();
        end

        // singular innovation: zero observation and noise gives zero determinant
        cv[CFG_SKIP] = '0;
        cv[CFG_OBS]  = '0;
        cv[CFG_RN]   = '0;
        load_config(cv);
        send_item(rand_item(1'b1));
        send_item(rand_item(1'b0));
        drain();

        // register extremes: largest positive, most negative, all ones
        for (int e = 0; e < 3; e++) begin
            for (int i = 0; i < 6; i++)
                cv[i] = (e == 0) ? {4{16'h7fff}} : (e == 1) ? {4{16'h8000}} : '1;
            cv[CFG_CTRL] &= 64'hffff_ffff;
            cv[CFG_MINV] = (e == 0) ? {2{32'h7fff_ffff}} : (e == 1) ? {2{32'h8000_0000}} : '1;
            cv[CFG_SKIP] = (e == 2) ? 64'h1f : 64'h0;
            load_config(cv);
            send_item({edges[e], edges[e+1], edges[e+3]});
            send_item(rand_item(1'b1));
            drain();
        end

        // random phases, each with its own register setting
        for (int ph = 0; ph < 11; ph++) begin
            if ($urandom_range(0, 9) < 7) sane_config(cv);
            else wild_config(cv);
            load_config(cv);
            n_items = $urandom_range(40, 60);
            for (int n = 0; n < n_items; n++) begin
                if (ph == 4 && n == 5) hold_req = 1'b1;
                if (ph == 7 && n == 20) drain();  // sender waits for all results
                send_paced(rand_item($urandom_range(0, 4) == 0));
            end
            drain();
        end

        repeat (600) @(posedge aclk);
        if (sb.pending() != 0) begin
            $error("%0d expected estimates never arrived", sb.pending());
            sb.errors++;
        end
        $display("covered %0d items, %0d results checked, %0d register settings",
                 sent, sb.checked, cfg_sets);
        $display("settings include reset values, extremes, every skip flag, zero determinant");
        if (sb.errors == 0) begin
            $display("[linear_kalman_filter_step] OK");
        end else begin
            $display("[linear_kalman_filter_step] ERROR");
        end
        $finish;
    end

    // guard against a hung handshake
    initial begin : watchdog
        #12ms;
        $display("[linear_kalman_filter_step] ERROR");
        $finish;
    end

endmodule
